FILE: hw/rtl/rmh_pkg.sv
`timescale 1ns / 1ps
package rmh_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned MedianW = 33;
  localparam int unsigned CountW  = 11;

  // Command from the sequencer to one heap.
  typedef struct packed {
    logic                      start;
    logic                      pop;
    logic signed [SampleW-1:0] data;
  } heap_cmd_t;

  // Status from one heap back to the sequencer.
  typedef struct packed {
    logic                      done;
    logic signed [SampleW-1:0] top;
  } heap_stat_t;

endpackage

FILE: hw/rtl/rmh_sample_if.sv
`timescale 1ns / 1ps
interface rmh_sample_if;
  import rmh_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

FILE: hw/rtl/rmh_result_if.sv
`timescale 1ns / 1ps
interface rmh_result_if;
  import rmh_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [MedianW-1:0] median_doubled;
  logic [CountW-1:0]         element_count;
  logic                      dropped;
  modport source (output valid, output median_doubled, output element_count,
                  output dropped, input ready);
  modport sink (input valid, input median_doubled, input element_count,
                input dropped, output ready);
endinterface

FILE: hw/rtl/rmh_heap.sv
`timescale 1ns / 1ps
module rmh_heap import rmh_pkg::*; #(
  parameter int unsigned DEPTH  = 512,
  parameter bit          IS_MAX = 1'b1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  heap_cmd_t                          cmd,
  output heap_stat_t                         stat,
  output logic [$clog2(DEPTH+1)-1:0]         size
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = $clog2(DEPTH + 1);
  localparam int unsigned CW = AW + 2;

  typedef enum logic [2:0] {
    H_IDLE, H_UP_RD, H_UP_CMP, H_POP_LAST, H_DN_L, H_DN_LW, H_DN_R
  } hstate_t;

  hstate_t                   state;
  logic [AW-1:0]             idx;
  logic [SW-1:0]             nlim;
  logic signed [SampleW-1:0] val;
  logic signed [SampleW-1:0] hl;
  logic                      best_l;
  logic                      done;

  logic signed [SampleW-1:0] mem [DEPTH];
  logic signed [SampleW-1:0] rd;
  logic signed [SampleW-1:0] top;
  logic [AW-1:0]             ra;
  logic                      we;
  logic [AW-1:0]             wa;
  logic signed [SampleW-1:0] wd;

  logic signed [SampleW-1:0] cmp_a;
  logic signed [SampleW-1:0] cmp_b;
  logic                      above;
  logic [AW-1:0]             parent;
  logic [CW-1:0]             lc;
  logic [CW-1:0]             rc;
  logic [SW-1:0]             size_dec;

  // Tree addressing and the single shared comparator.
  assign parent   = AW'((idx - AW'(1)) >> 1);
  assign lc       = {1'b0, idx, 1'b1};
  assign rc       = lc + CW'(1);
  assign size_dec = size - SW'(1);
  assign above    = IS_MAX ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

  always_comb begin
    cmp_a = rd;
    cmp_b = hl;
    unique case (state)
      H_UP_CMP: begin
        cmp_a = val;
        cmp_b = rd;
      end
      H_DN_LW: begin
        cmp_a = rd;
        cmp_b = val;
      end
      H_DN_R: begin
        cmp_a = rd;
        cmp_b = best_l ? hl : val;
      end
      default: begin
        cmp_a = rd;
        cmp_b = hl;
      end
    endcase
  end

  // Memory port control for each step of a sift.
  always_comb begin
    ra = '0;
    we = 1'b0;
    wa = idx;
    wd = val;
    unique case (state)
      H_IDLE: begin
        ra = AW'(size_dec);
      end
      H_UP_RD: begin
        ra = parent;
        if (idx == '0) begin
          we = 1'b1;
        end
      end
      H_UP_CMP: begin
        we = 1'b1;
        wd = above ? rd : val;
      end
      H_POP_LAST: begin
        ra = '0;
      end
      H_DN_L: begin
        ra = lc[AW-1:0];
        we = !(lc < CW'(nlim));
      end
      H_DN_LW: begin
        ra = rc[AW-1:0];
        if (!(rc < CW'(nlim))) begin
          we = 1'b1;
          wd = above ? rd : val;
        end
      end
      H_DN_R: begin
        we = 1'b1;
        wd = above ? rd : (best_l ? hl : val);
      end
      default: begin
        ra = '0;
      end
    endcase
  end

  // Heap storage with registered read, and a copy of the root.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
    if (we && wa == '0) begin
      top <= wd;
    end
  end

  // Sift sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      size  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        H_IDLE: begin
          if (cmd.start && !cmd.pop) begin
            size  <= size + SW'(1);
            idx   <= AW'(size);
            val   <= cmd.data;
            state <= H_UP_RD;
          end else if (cmd.start) begin
            size <= size_dec;
            nlim <= size_dec;
            if (size_dec == '0) begin
              done <= 1'b1;
            end else begin
              state <= H_POP_LAST;
            end
          end
        end
        H_UP_RD: begin
          if (idx == '0) begin
            done  <= 1'b1;
            state <= H_IDLE;
          end else begin
            state <= H_UP_CMP;
          end
        end
        H_UP_CMP: begin
          if (above) begin
            idx   <= parent;
            state <= H_UP_RD;
          end else begin
            done  <= 1'b1;
            state <= H_IDLE;
          end
        end
        H_POP_LAST: begin
          val   <= rd;
          idx   <= '0;
          state <= H_DN_L;
        end
        H_DN_L: begin
          if (lc < CW'(nlim)) begin
            state <= H_DN_LW;
          end else begin
            done  <= 1'b1;
            state <= H_IDLE;
          end
        end
        H_DN_LW: begin
          hl     <= rd;
          best_l <= above;
          if (rc < CW'(nlim)) begin
            state <= H_DN_R;
          end else if (above) begin
            idx   <= lc[AW-1:0];
            state <= H_DN_L;
          end else begin
            done  <= 1'b1;
            state <= H_IDLE;
          end
        end
        H_DN_R: begin
          if (above) begin
            idx   <= rc[AW-1:0];
            state <= H_DN_L;
          end else if (best_l) begin
            idx   <= lc[AW-1:0];
            state <= H_DN_L;
          end else begin
            done  <= 1'b1;
            state <= H_IDLE;
          end
        end
        default: begin
          state <= H_IDLE;
        end
      endcase
    end
  end

  assign stat.done = done;
  assign stat.top  = top;

endmodule

FILE: hw/rtl/running_median_two_heaps.sv
`timescale 1ns / 1ps
// Channel   Dir  Interface      Word
// samples   in   rmh_sample_if  sample (signed 32)
// results   out  rmh_result_if  median_doubled (signed 33), element_count, dropped
//
// One word is taken at a time; ready is high only between words.
// A plain insert sifts up one heap level at a time; a rebalance first pops the top
// of one heap, sifting down level by level, and pushes it into the other. Heaps
// hold 512 entries each by default. The heap memories, each with one read and one
// write port, and each heap's single shared comparator set the pace of every sift.
// Reset clears both heap sizes; heap contents are not cleared.
// The result word waits in its register until taken; no new sample enters meanwhile.
module running_median_two_heaps import rmh_pkg::*; #(
  parameter int unsigned HEAP_DEPTH = 512
) (
  input  logic         clk,
  input  logic         rst,
  rmh_sample_if.sink   samples,
  rmh_result_if.source results
);

  localparam int unsigned SW = $clog2(HEAP_DEPTH + 1);

  typedef enum logic [3:0] {
    T_IDLE, T_POP, T_POP_W, T_PUSHT, T_PUSHT_W, T_PUSHX, T_PUSHX_W, T_MED, T_OUT
  } tstate_t;

  tstate_t                   state;
  logic signed [SampleW-1:0] x;
  logic signed [SampleW-1:0] t;
  logic                      x_up;
  logic                      drop;
  logic signed [MedianW-1:0] med;
  logic [CountW-1:0]         cnt;

  heap_cmd_t                 lcmd;
  heap_cmd_t                 ucmd;
  heap_stat_t                lstat;
  heap_stat_t                ustat;
  logic [SW-1:0]             lsize;
  logic [SW-1:0]             usize;

  logic                      full;
  logic                      go_up;
  logic                      move;
  logic                      op_done;
  logic signed [MedianW-1:0] lt;
  logic signed [MedianW-1:0] ut;

  rmh_heap #(.DEPTH(HEAP_DEPTH), .IS_MAX(1'b1)) u_lower (
    .clk(clk), .rst(rst), .cmd(lcmd), .stat(lstat), .size(lsize)
  );

  rmh_heap #(.DEPTH(HEAP_DEPTH), .IS_MAX(1'b0)) u_upper (
    .clk(clk), .rst(rst), .cmd(ucmd), .stat(ustat), .size(usize)
  );

  // Placement decision for an incoming sample.
  assign full = (lsize == SW'(HEAP_DEPTH)) && (usize == SW'(HEAP_DEPTH));
  always_comb begin
    go_up = 1'b0;
    move  = 1'b0;
    priority if (lsize == usize) begin
      go_up = (lsize != '0) && !(samples.sample < lstat.top);
    end else if (lsize > usize) begin
      go_up = !(samples.sample < lstat.top);
      move  = !go_up;
    end else begin
      go_up = samples.sample > ustat.top;
      move  = go_up;
    end
  end

  // Heap commands follow the sequencer state.
  assign op_done = lstat.done || ustat.done;
  always_comb begin
    lcmd.pop   = (state == T_POP);
    ucmd.pop   = (state == T_POP);
    lcmd.data  = (state == T_PUSHT) ? t : x;
    ucmd.data  = (state == T_PUSHT) ? t : x;
    lcmd.start = ((state == T_POP) && !x_up) || ((state == T_PUSHT) && x_up) ||
                 ((state == T_PUSHX) && !x_up);
    ucmd.start = ((state == T_POP) && x_up) || ((state == T_PUSHT) && !x_up) ||
                 ((state == T_PUSHX) && x_up);
  end

  // Tops as seen by the median, zero for an empty heap.
  assign lt = (lsize != '0) ? MedianW'(lstat.top) : '0;
  assign ut = (usize != '0) ? MedianW'(ustat.top) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (samples.valid) begin
            x    <= samples.sample;
            x_up <= go_up;
            drop <= full;
            if (full) begin
              state <= T_MED;
            end else if (move) begin
              state <= T_POP;
            end else begin
              state <= T_PUSHX;
            end
          end
        end
        T_POP: begin
          t     <= x_up ? ustat.top : lstat.top;
          state <= T_POP_W;
        end
        T_POP_W: begin
          if (op_done) begin
            state <= T_PUSHT;
          end
        end
        T_PUSHT: begin
          state <= T_PUSHT_W;
        end
        T_PUSHT_W: begin
          if (op_done) begin
            state <= T_PUSHX;
          end
        end
        T_PUSHX: begin
          state <= T_PUSHX_W;
        end
        T_PUSHX_W: begin
          if (op_done) begin
            state <= T_MED;
          end
        end
        T_MED: begin
          priority if (lsize == usize) begin
            med <= lt + ut;
          end else if (lsize > usize) begin
            med <= lt <<< 1;
          end else begin
            med <= ut <<< 1;
          end
          cnt   <= CountW'(lsize) + CountW'(usize);
          state <= T_OUT;
        end
        T_OUT: begin
          if (results.ready) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  assign samples.ready          = (state == T_IDLE);
  assign results.valid          = (state == T_OUT);
  assign results.median_doubled = med;
  assign results.element_count  = cnt;
  assign results.dropped        = drop;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import rmh_pkg::*;

  localparam int unsigned Depth      = 512;
  localparam int unsigned NumRandom  = 1400;
  localparam int unsigned QuietTail  = 150;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 100;

  // Heap indexes in the predictor.
  localparam int unsigned LowerHeap = 0;
  localparam int unsigned UpperHeap = 1;

  typedef struct packed {
    logic signed [MedianW-1:0] median_doubled;
    logic [CountW-1:0]         element_count;
    logic                      dropped;
  } median_word_t;

  logic clk;
  logic rst;

  rmh_sample_if sample_bus ();
  rmh_result_if result_bus ();

  running_median_two_heaps #(.HEAP_DEPTH(Depth)) dut (
    .clk    (clk),
    .rst    (rst),
    .samples(sample_bus.sink),
    .results(result_bus.source)
  );

  // Predictor state: lower half is a max-heap, upper half a min-heap.
  logic signed [SampleW-1:0] heap_mem [2][Depth];
  int unsigned               heap_len [2];

  logic signed [SampleW-1:0] pending_samples [$];
  median_word_t              expected_medians [$];
  int unsigned               error_count;
  int unsigned               cycle_count;

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  function automatic bit ranks_higher(int unsigned h, logic signed [SampleW-1:0] a,
                                      logic signed [SampleW-1:0] b);
    return (h == LowerHeap) ? (a > b) : (a < b);
  endfunction

  function automatic void heap_insert(int unsigned h, logic signed [SampleW-1:0] v);
    int unsigned i;
    int unsigned p;
    logic signed [SampleW-1:0] t;
    i = heap_len[h];
    if (i >= Depth) return;
    heap_mem[h][i] = v;
    heap_len[h] = i + 1;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!ranks_higher(h, heap_mem[h][i], heap_mem[h][p])) break;
      t = heap_mem[h][p];
      heap_mem[h][p] = heap_mem[h][i];
      heap_mem[h][i] = t;
      i = p;
    end
  endfunction

  function automatic logic signed [SampleW-1:0] heap_extract(int unsigned h);
    int unsigned n;
    int unsigned i;
    int unsigned l;
    int unsigned r;
    int unsigned best;
    logic signed [SampleW-1:0] top;
    logic signed [SampleW-1:0] t;
    n = heap_len[h];
    i = 0;
    if (n == 0) return '0;
    top = heap_mem[h][0];
    n--;
    heap_len[h] = n;
    heap_mem[h][0] = heap_mem[h][n];
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      best = i;
      if (l < n && ranks_higher(h, heap_mem[h][l], heap_mem[h][best])) best = l;
      if (r < n && ranks_higher(h, heap_mem[h][r], heap_mem[h][best])) best = r;
      if (best == i) break;
      t = heap_mem[h][best];
      heap_mem[h][best] = heap_mem[h][i];
      heap_mem[h][i] = t;
      i = best;
    end
    return top;
  endfunction

  // Add one sample to the running set and return the word the block should report.
  function automatic median_word_t insert_and_median(logic signed [SampleW-1:0] x);
    median_word_t w;
    logic signed [MedianW-1:0] lt;
    logic signed [MedianW-1:0] ut;
    w.dropped = 1'b0;
    if (heap_len[LowerHeap] >= Depth && heap_len[UpperHeap] >= Depth) begin
      w.dropped = 1'b1;
    end else if (heap_len[LowerHeap] == heap_len[UpperHeap]) begin
      if (heap_len[LowerHeap] == 0 || x < heap_mem[LowerHeap][0]) begin
        heap_insert(LowerHeap, x);
      end else begin
        heap_insert(UpperHeap, x);
      end
    end else if (heap_len[LowerHeap] > heap_len[UpperHeap]) begin
      if (x >= heap_mem[LowerHeap][0]) begin
        heap_insert(UpperHeap, x);
      end else begin
        heap_insert(UpperHeap, heap_extract(LowerHeap));
        heap_insert(LowerHeap, x);
      end
    end else begin
      if (x <= heap_mem[UpperHeap][0]) begin
        heap_insert(LowerHeap, x);
      end else begin
        heap_insert(LowerHeap, heap_extract(UpperHeap));
        heap_insert(UpperHeap, x);
      end
    end
    lt = (heap_len[LowerHeap] > 0) ? MedianW'(heap_mem[LowerHeap][0]) : '0;
    ut = (heap_len[UpperHeap] > 0) ? MedianW'(heap_mem[UpperHeap][0]) : '0;
    if (heap_len[LowerHeap] == heap_len[UpperHeap]) w.median_doubled = lt + ut;
    else if (heap_len[LowerHeap] > heap_len[UpperHeap]) w.median_doubled = lt <<< 1;
    else w.median_doubled = ut <<< 1;
    w.element_count = CountW'(heap_len[LowerHeap] + heap_len[UpperHeap]);
    return w;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Sample driver: holds each word until accepted, with random gaps.
  int unsigned send_gap;
  always @(posedge clk) begin
    if (rst) begin
      sample_bus.valid <= 1'b0;
      sample_bus.sample <= '0;
      send_gap = 0;
    end else begin
      if (sample_bus.valid && sample_bus.ready) begin
        expected_medians.push_back(insert_and_median(sample_bus.sample));
      end
      if (!sample_bus.valid || sample_bus.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          sample_bus.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          if (pending_samples.size() > QuietTail && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 5);
            sample_bus.valid <= 1'b0;
          end else begin
            sample_bus.valid <= 1'b1;
            sample_bus.sample <= pending_samples.pop_front();
          end
        end else begin
          sample_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted word, stalls ready in random bursts.
  int unsigned stall_left;
  median_word_t want_word;
  always @(posedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        if (expected_medians.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want_word = expected_medians.pop_front();
          if (result_bus.median_doubled !== want_word.median_doubled)
            report_mismatch("median_doubled", result_bus.median_doubled,
                            want_word.median_doubled);
          if (result_bus.element_count !== want_word.element_count)
            report_mismatch("element_count", result_bus.element_count,
                            want_word.element_count);
          if (result_bus.dropped !== want_word.dropped)
            report_mismatch("dropped", result_bus.dropped, want_word.dropped);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else if (pending_samples.size() > QuietTail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 5);
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Random sample: mostly full range, with clusters that force ties and extremes.
  function automatic logic signed [SampleW-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick < 2) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    if (pick < 6) return SampleW'($signed($urandom_range(0, 16)) - 8);
    return $urandom;
  endfunction

  initial begin
    error_count = 0;
    cycle_count = 0;
    heap_len[LowerHeap] = 0;
    heap_len[UpperHeap] = 0;
    sample_bus.valid = 1'b0;
    sample_bus.sample = '0;
    result_bus.ready = 1'b0;
    rst = 1'b1;

    // Directed words: extremes, equal values against both tops, rebalances.
    pending_samples = '{32'sd0, 32'sh7fffffff, 32'sh80000000, -32'sd1, 32'sd1,
                        32'sd0, 32'sd0, 32'sh7fffffff, 32'sh7fffffff,
                        32'sh80000000, 32'sh80000000, 32'sh80000000,
                        32'sd5, 32'sd5, -32'sd5, 32'sd1, -32'sd1, 32'sh55555555,
                        32'shaaaaaaaa, 32'sd2, 32'sd3};
    repeat (NumRandom) pending_samples.push_back(random_sample());

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    wait (pending_samples.size() == 0 && !sample_bus.valid);
    wait (expected_medians.size() == 0);
    repeat (DrainWait) @(posedge clk);
    if (error_count == 0 && expected_medians.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

FILE: running_median_two_heaps.f
hw/rtl/rmh_pkg.sv
hw/rtl/rmh_sample_if.sv
hw/rtl/rmh_result_if.sv
hw/rtl/rmh_heap.sv
hw/rtl/running_median_two_heaps.sv
tb/tb.sv
